FILE: hdl/sfd_pkg.sv
// Shared types, codes and the build-time FIR tap tables of the streaming FIR decimator.
package sfd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 18;
	localparam int MAX_TAPS    = 129;
	localparam int ACC_W       = 48;
	localparam int MAX_RESULTS = 16;
	localparam int TAP_W       = 8;
	localparam int K_W         = 5;
	localparam int RCV_W       = 32;
	localparam int MID_W       = 34;
	localparam int POS_W       = 36;
	localparam int FRAC_BITS   = COEF_W - 1;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint WIN_A = 64'sd579820585;
	localparam longint WIN_B = 64'sd493921239;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_FINISH  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DONE    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DSEL_PASS = 2'd0,
		DSEL_DIV2 = 2'd1
	} dsel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_STATUS,
		S_PUSH_CHK,
		S_MAC,
		S_DRAIN,
		S_RESULT,
		S_NEXT
	} state_t;

	typedef struct packed {
		logic    latch_in;
		logic    push_commit;
		logic    restart;
		logic    mac_start;
		logic    fin;
		logic    mac_step;
		logic    out_load;
		logic    out_has;
		status_t out_status;
		logic    out_last;
		logic    advance;
		logic    set_done;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       done;
		logic       rcv_zero;
		logic       rcv_full;
		logic       push_emit;
		logic       flush_more;
		logic       flush_more_next;
		logic       tap_last;
		logic       mac_idle;
		logic       out_free;
	} sts_t;

	typedef logic signed [COEF_W-1:0] coef_tab_t [MAX_TAPS];

	function automatic longint unsigned mag64(longint a);
		return (a < 0) ? -a : a;
	endfunction

	// Shift-and-subtract quotient; only used while the tap tables are built.
	function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sine of m/640 of a turn in Q30, Taylor series on the first quadrant.
	function automatic longint sin640(longint unsigned m);
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned den;
		longint s;
		bit neg;
		r = m - udiv64(m, 640) * 640;
		neg = 1'b0;
		if (r >= 320) begin
			neg = 1'b1;
			r = r - 320;
		end
		if (r > 160)
			r = 320 - r;
		x = udiv64(r * PI_Q30 + 160, 320);
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		s = x;
		for (int k = 1; k <= 7; k++) begin
			den = 64'((2 * k) * (2 * k + 1));
			term = udiv64((term * x2) >> 30, den);
			if (k % 2 == 1)
				s = s - longint'(term);
			else
				s = s + longint'(term);
		end
		return neg ? -s : s;
	endfunction

	function automatic longint mulq30(longint a, longint b);
		longint unsigned p;
		p = (mag64(a) * mag64(b) + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	// Hamming-windowed sinc taps, normalized to unity gain, for factor f (2 or 4).
	function automatic coef_tab_t build_taps(int f);
		coef_tab_t tab;
		longint raw [MAX_TAPS];
		longint tot;
		longint sp;
		longint sv;
		longint w;
		longint o;
		longint ao;
		longint unsigned totu;
		longint unsigned q;
		int n;
		int half;
		int fsh;
		int astep;
		int wstep;
		tab = '{default: '0};
		raw = '{default: 0};
		tot = 0;
		fsh = (f == 4) ? 2 : 1;
		n = 32 * f + 1;
		half = 16 * f;
		astep = 288 >> fsh;
		wstep = 20 >> fsh;
		for (int i = 0; i < n; i++) begin
			o = i - half;
			ao = (o < 0) ? -o : o;
			if (o == 0) begin
				sp = longint'(udiv64(longint'(astep) * PI_Q30 + 160, 320));
			end else begin
				// Truncating division of a signed value by a positive offset.
				sv = sin640(longint'(astep) * ao);
				q = udiv64(mag64(sv), ao);
				sp = (sv < 0) ? -longint'(q) : longint'(q);
			end
			w = WIN_A - mulq30(WIN_B, sin640(longint'(wstep * i + 160)));
			raw[i] = mulq30(sp, w);
			tot = tot + raw[i];
		end
		if (tot <= 0)
			tot = 1;
		totu = tot;
		for (int i = 0; i < n; i++) begin
			q = udiv64((mag64(raw[i]) << FRAC_BITS) + (totu >> 1), totu);
			tab[i] = COEF_W'((raw[i] < 0) ? -longint'(q) : longint'(q));
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF_F2 = build_taps(2);
	localparam coef_tab_t COEF_F4 = build_taps(4);

endpackage

FILE: hdl/sfd_ctrl.sv
// Sequencing state machine of the streaming FIR decimator.
module sfd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sfd_pkg::sts_t sts,
	output sfd_pkg::cmd_t cmd
);

	sfd_pkg::state_t  state_q, state_d;
	sfd_pkg::status_t stat_q, stat_d;
	logic             fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfd_pkg::S_IDLE;
			stat_q  <= sfd_pkg::ST_OK;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			fin_q   <= fin_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfd_pkg::S_IDLE: begin
				if (in_valid)
					state_d = sfd_pkg::S_DECIDE;
			end
			sfd_pkg::S_DECIDE: begin
				state_d = sfd_pkg::S_STATUS;
				if (sts.op == sfd_pkg::OP_PUSH && !sts.done && !sts.rcv_full)
					state_d = sfd_pkg::S_PUSH_CHK;
				else if (sts.op == sfd_pkg::OP_FINISH && !sts.done && !sts.rcv_zero &&
				         sts.flush_more)
					state_d = sfd_pkg::S_MAC;
			end
			sfd_pkg::S_PUSH_CHK: begin
				state_d = sts.push_emit ? sfd_pkg::S_MAC : sfd_pkg::S_STATUS;
			end
			sfd_pkg::S_STATUS: begin
				if (sts.out_free)
					state_d = sfd_pkg::S_IDLE;
			end
			sfd_pkg::S_MAC: begin
				if (sts.tap_last)
					state_d = sfd_pkg::S_DRAIN;
			end
			sfd_pkg::S_DRAIN: begin
				if (sts.mac_idle)
					state_d = sfd_pkg::S_RESULT;
			end
			sfd_pkg::S_RESULT: begin
				if (sts.out_free)
					state_d = fin_q ? sfd_pkg::S_NEXT : sfd_pkg::S_IDLE;
			end
			sfd_pkg::S_NEXT: begin
				state_d = sts.flush_more ? sfd_pkg::S_MAC : sfd_pkg::S_IDLE;
			end
			default: state_d = sfd_pkg::S_IDLE;
		endcase
	end

	// Outputs and command strobes.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		stat_d   = stat_q;
		fin_d    = fin_q;
		case (state_q)
			sfd_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			sfd_pkg::S_DECIDE: begin
				fin_d = 1'b0;
				case (sts.op)
					sfd_pkg::OP_PUSH: begin
						if (sts.done)
							stat_d = sfd_pkg::ST_DONE;
						else if (sts.rcv_full)
							stat_d = sfd_pkg::ST_INVALID;
						else
							cmd.push_commit = 1'b1;
					end
					sfd_pkg::OP_FINISH: begin
						if (sts.done) begin
							stat_d = sfd_pkg::ST_DONE;
						end else if (sts.rcv_zero) begin
							stat_d = sfd_pkg::ST_INVALID;
						end else if (sts.flush_more) begin
							cmd.mac_start = 1'b1;
							cmd.fin       = 1'b1;
							fin_d         = 1'b1;
						end else begin
							cmd.set_done = 1'b1;
							stat_d       = sfd_pkg::ST_OK;
						end
					end
					sfd_pkg::OP_RESTART: begin
						cmd.restart = 1'b1;
						stat_d      = sfd_pkg::ST_OK;
					end
					default: stat_d = sfd_pkg::ST_INVALID;
				endcase
			end
			sfd_pkg::S_PUSH_CHK: begin
				stat_d = sfd_pkg::ST_OK;
				cmd.mac_start = sts.push_emit;
			end
			sfd_pkg::S_STATUS: begin
				cmd.out_load   = sts.out_free;
				cmd.out_status = stat_q;
				cmd.out_last   = 1'b1;
			end
			sfd_pkg::S_MAC: begin
				cmd.mac_step = 1'b1;
			end
			sfd_pkg::S_RESULT: begin
				cmd.out_load   = sts.out_free;
				cmd.out_has    = 1'b1;
				cmd.out_status = sfd_pkg::ST_OK;
				cmd.out_last   = !(fin_q && sts.flush_more_next);
				cmd.advance    = sts.out_free;
			end
			sfd_pkg::S_NEXT: begin
				// A flush continues while outputs remain and the result budget lasts.
				cmd.mac_start = sts.flush_more;
				cmd.fin       = 1'b1;
				cmd.set_done  = !sts.flush_more;
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hdl/sfd_datapath.sv
// Stream state, sample ring, shared multiply-accumulate and output register.
module sfd_datapath #(
	parameter int RING_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [1:0]                           cfg_write_data,
	input  logic [1:0]                           operation,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0]  sample,
	input  sfd_pkg::cmd_t                        cmd,
	output sfd_pkg::sts_t                        sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sfd_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                                 has_sample,
	output logic [1:0]                           status,
	output logic                                 last_in_run
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(RING_DEPTH);
	localparam logic [AW-1:0] ADDR_LAST = AW'(RING_DEPTH - 1);

	logic [1:0]                          dsel_q;
	logic [1:0]                          op_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] sample_q;
	logic [sfd_pkg::RCV_W-1:0]           rcv_q;
	logic [sfd_pkg::MID_W-1:0]           mid_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] first_q, last_q;
	logic                                done_q;
	logic [2:0]                          fac_q;
	logic [AW-1:0]                       wr_ptr_q, base_q, addr_q;
	logic [sfd_pkg::K_W-1:0]             k_q;
	logic [sfd_pkg::TAP_W-1:0]           tap_q;
	logic signed [sfd_pkg::POS_W-1:0]    pos_q;
	logic                                fin_q;

	logic signed [sfd_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];

	logic                                vld_s1, vld_s2;
	logic                                sel_first_s1, sel_last_s1;
	logic signed [sfd_pkg::SAMPLE_W-1:0] rd_s1;
	logic signed [sfd_pkg::COEF_W:0]     coef_s1;
	logic signed [sfd_pkg::SAMPLE_W+sfd_pkg::COEF_W:0] prod_s2;
	logic signed [sfd_pkg::ACC_W-1:0]    acc_q;

	logic                                out_valid_q, has_q, last_q_out;
	logic [1:0]                          status_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] out_q;

	logic [2:0]                          fac_new;
	logic [6:0]                          half;
	logic [sfd_pkg::TAP_W-1:0]           tap_end;
	logic [sfd_pkg::MID_W:0]             mid_ext, rcv_ext;
	logic signed [sfd_pkg::COEF_W:0]     coef_sel;
	logic signed [sfd_pkg::SAMPLE_W-1:0] x_s1;
	logic [AW:0]                         base_sum, start_sum;
	logic signed [sfd_pkg::ACC_W-1:0]    rnd;
	logic signed [sfd_pkg::ACC_W-1:0]    shifted;
	logic signed [sfd_pkg::SAMPLE_W-1:0] sat_val;
	logic                                out_free;

	always_comb begin
		case (dsel_q)
			sfd_pkg::DSEL_PASS: fac_new = 3'd1;
			sfd_pkg::DSEL_DIV2: fac_new = 3'd2;
			default:            fac_new = 3'd4;
		endcase
	end

	// Half window and last tap index of the running stream's factor.
	always_comb begin
		case (fac_q)
			3'd2:    begin half = 7'd32; tap_end = sfd_pkg::TAP_W'(64);  end
			3'd4:    begin half = 7'd64; tap_end = sfd_pkg::TAP_W'(128); end
			default: begin half = 7'd0;  tap_end = '0;                   end
		endcase
	end

	assign mid_ext = {1'b0, mid_q};
	assign rcv_ext = {3'b0, rcv_q};

	assign base_sum  = {1'b0, base_q} + {(AW - 2)'(0), fac_q};
	assign start_sum = ({1'b0, base_q} >= {(AW - 6)'(0), half}) ?
		{1'b0, base_q} - {(AW - 6)'(0), half} :
		{1'b0, base_q} + DEPTH_V - {(AW - 6)'(0), half};

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.op              = op_q;
		sts.done            = done_q;
		sts.rcv_zero        = (rcv_q == '0);
		sts.rcv_full        = (rcv_q == '1);
		sts.push_emit       = rcv_ext >= mid_ext + {28'd0, half} + 35'd1;
		sts.flush_more      = (mid_ext + {32'd0, fac_q} <= rcv_ext) &&
		                      (k_q < sfd_pkg::K_W'(sfd_pkg::MAX_RESULTS));
		sts.flush_more_next = (mid_ext + {31'd0, fac_q, 1'b0} <= rcv_ext) &&
		                      (k_q < sfd_pkg::K_W'(sfd_pkg::MAX_RESULTS - 1));
		sts.tap_last        = (tap_q == tap_end);
		sts.mac_idle        = !vld_s1 && !vld_s2;
		sts.out_free        = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dsel_q <= sfd_pkg::DSEL_PASS;
		else if (cfg_write_en)
			dsel_q <= cfg_write_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q     <= operation;
			sample_q <= sample;
		end
	end

	// Stream bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q    <= '0;
			mid_q    <= '0;
			first_q  <= '0;
			last_q   <= '0;
			done_q   <= 1'b0;
			fac_q    <= 3'd1;
			wr_ptr_q <= '0;
			base_q   <= '0;
			k_q      <= '0;
		end else begin
			if (cmd.latch_in)
				k_q <= '0;
			if (cmd.restart) begin
				rcv_q    <= '0;
				mid_q    <= '0;
				first_q  <= '0;
				last_q   <= '0;
				done_q   <= 1'b0;
				wr_ptr_q <= '0;
				base_q   <= '0;
			end
			if (cmd.push_commit) begin
				if (rcv_q == '0) begin
					fac_q   <= fac_new;
					first_q <= sample_q;
				end
				last_q   <= sample_q;
				rcv_q    <= rcv_q + 1'b1;
				wr_ptr_q <= (wr_ptr_q == ADDR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd.advance) begin
				mid_q  <= mid_q + {31'd0, fac_q};
				base_q <= (base_sum >= DEPTH_V) ? AW'(base_sum - DEPTH_V) : AW'(base_sum);
				k_q    <= k_q + 1'b1;
			end
			if (cmd.set_done)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_commit)
			ring_mem[wr_ptr_q] <= sample_q;
		rd_s1 <= ring_mem[addr_q];
	end

	// Tap walker: window position, ring address and tap index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			fin_q <= 1'b0;
		end else if (cmd.mac_start) begin
			tap_q <= '0;
			fin_q <= cmd.fin;
		end else if (cmd.mac_step) begin
			tap_q <= tap_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_start) begin
			pos_q  <= $signed({2'b0, mid_q}) - $signed({29'd0, half});
			addr_q <= AW'(start_sum);
		end else if (cmd.mac_step) begin
			pos_q  <= pos_q + sfd_pkg::POS_W'(1);
			addr_q <= (addr_q == ADDR_LAST) ? '0 : addr_q + 1'b1;
		end
	end

	// One extra bit so that the pass-through tap of exactly one fits.
	always_comb begin
		case (fac_q)
			3'd2:    coef_sel = (sfd_pkg::COEF_W + 1)'(sfd_pkg::COEF_F2[tap_q]);
			3'd4:    coef_sel = (sfd_pkg::COEF_W + 1)'(sfd_pkg::COEF_F4[tap_q]);
			default: coef_sel = (sfd_pkg::COEF_W + 1)'(1 << sfd_pkg::FRAC_BITS);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mac_step;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sel_first_s1 <= pos_q[sfd_pkg::POS_W-1];
		sel_last_s1  <= fin_q && !pos_q[sfd_pkg::POS_W-1] &&
		                (pos_q[sfd_pkg::POS_W-2:0] >= {3'd0, rcv_q});
		coef_s1      <= coef_sel;
	end

	// Positions before the stream repeat the first sample, after it the last one.
	assign x_s1 = sel_first_s1 ? first_q : (sel_last_s1 ? last_q : rd_s1);

	always_ff @(posedge clk) begin
		prod_s2 <= x_s1 * coef_s1;
		if (cmd.mac_start)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= acc_q + sfd_pkg::ACC_W'(prod_s2);
	end

	// Round half up, then saturate.
	assign rnd     = acc_q + sfd_pkg::ACC_W'(1 << (sfd_pkg::FRAC_BITS - 1));
	assign shifted = rnd >>> sfd_pkg::FRAC_BITS;
	always_comb begin
		if (shifted > sfd_pkg::ACC_W'(32767))
			sat_val = 16'sh7fff;
		else if (shifted < -sfd_pkg::ACC_W'(32768))
			sat_val = 16'sh8000;
		else
			sat_val = shifted[sfd_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q      <= cmd.out_has ? sat_val : '0;
			has_q      <= cmd.out_has;
			status_q   <= cmd.out_status;
			last_q_out <= cmd.out_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_q;
	assign has_sample  = has_q;
	assign status      = status_q;
	assign last_in_run = last_q_out;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free) else $error("result register overwritten");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1)) else $error("product without a tap read");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_start |-> (!vld_s1 && !vld_s2)) else $error("sum started while busy");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_commit |-> (rcv_q != '1)) else $error("sample count wrapped");

endmodule

FILE: hdl/streaming_fir_decimator_unit.sv
// Top level of the streaming FIR decimator: controller plus datapath.
// Each item is handled alone. Restart or a rejected item passes through the
// decide and status states before the next acceptance, a push with no output also
// through the push check. A push that releases an output walks the shared
// multiply-accumulate over the window, one tap a cycle (1, 65 or 129 taps for
// factor 1, 2 or 4), then drains the tap-read, product and accumulate registers
// and loads the result. A finish emits up to sixteen tail outputs, each a full
// window walk. The single multiply-accumulate and the one-read-a-cycle sample
// ring set this tap rate. Results and status responses wait in an output
// register; a slow sink stalls the block only when the next one is ready.
module streaming_fir_decimator_unit #(
	parameter int RING_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [1:0]                          cfg_write_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sfd_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                has_sample,
	output logic [1:0]                          status,
	output logic                                last_in_run
);

	sfd_pkg::cmd_t cmd;
	sfd_pkg::sts_t sts;

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfd_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.operation      (operation),
		.sample         (sample),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_sample     (out_sample),
		.has_sample     (has_sample),
		.status         (status),
		.last_in_run    (last_in_run)
	);

endmodule
